>>> hdl/sged_pkg.sv
// Shared constants, word types and control structs for the semi-global edit distance block.
`timescale 1ns / 1ps

package sged_pkg;

  localparam int unsigned MAX_PATTERN = 32;
  localparam int unsigned MAX_TEXT    = 64;

  // pattern length / cell index width
  localparam int unsigned PLW = $clog2(MAX_PATTERN + 1);
  // score width, holds pattern length plus one
  localparam int unsigned SCW = $clog2(MAX_PATTERN + 2);
  // text position width
  localparam int unsigned TPW = $clog2(MAX_TEXT + 1);

  localparam int unsigned CFG_AW = 2;
  localparam int unsigned CFG_DW = 32;
  localparam int unsigned MAXW   = 6;

  localparam logic [CFG_AW-1:0] REG_MAX_EDIT_ADDR = CFG_AW'(0);
  localparam logic [MAXW-1:0]   MAX_EDIT_RESET    = MAXW'(2);

  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_TEXT    = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] symbol;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic [5:0] distance;
    logic       no_match;
    logic [6:0] end_position;
  } out_word_t;

  // text symbol travelling down the cell row
  typedef struct packed {
    logic           valid;
    logic           upd;
    logic           last;
    logic [7:0]     symbol;
    logic [SCW-1:0] left;
    logic [SCW-1:0] diag;
  } token_t;

  // pattern load / restart broadcast
  typedef struct packed {
    logic           restart;
    logic           wr;
    logic [PLW-1:0] idx;
    logic [PLW-1:0] len;
    logic [7:0]     symbol;
  } load_t;

endpackage

>>> hdl/sged_cell.sv
// One DP cell: holds one pattern symbol and its row score, passes the wavefront on.
`timescale 1ns / 1ps

module sged_cell
  import sged_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [PLW-1:0] idx_i,
  input  logic [PLW-1:0] len_i,
  input  load_t          load_i,
  input  logic           adv_i,
  input  token_t         tok_i,
  output token_t         tok_o
);

  logic [7:0]     pat_q;
  logic [SCW-1:0] score_q, score_d;
  logic           fresh_q, fresh_d;
  token_t         tok_q, tok_d;
  logic [SCW-1:0] score_eff, m, v;
  logic           active;

  // a fresh cell reads as its row index
  assign score_eff = fresh_q ? SCW'(idx_i) : score_q;
  assign active    = tok_i.valid && tok_i.upd && (idx_i <= len_i);

  always_comb begin
    m = (score_eff < tok_i.left) ? score_eff : tok_i.left;
    m = (m < tok_i.diag) ? m : tok_i.diag;
    if (pat_q == tok_i.symbol) begin
      v = tok_i.diag;
    end else begin
      v = m + SCW'(1);
    end
  end

  always_comb begin
    tok_d      = tok_i;
    tok_d.diag = score_eff;
    tok_d.left = active ? v : tok_i.left;
    fresh_d    = fresh_q;
    score_d    = score_q;
    if (load_i.restart) begin
      fresh_d = 1'b1;
    end else if (adv_i && tok_i.valid) begin
      if (tok_i.last) begin
        fresh_d = 1'b1;
      end else if (active) begin
        fresh_d = 1'b0;
        score_d = v;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= '0;
      fresh_q <= 1'b1;
    end else begin
      fresh_q <= fresh_d;
      if (adv_i) begin
        tok_q <= tok_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    score_q <= score_d;
    if (load_i.wr && (load_i.idx == idx_i)) begin
      pat_q <= load_i.symbol;
    end
  end

  assign tok_o = tok_q;

endmodule

>>> hdl/sged_tail.sv
// End of the cell row: tracks the best last-row score and holds the result word.
`timescale 1ns / 1ps

module sged_tail
  import sged_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  token_t          tok_i,
  input  load_t           load_i,
  input  logic [PLW-1:0]  len_i,
  input  logic [MAXW-1:0] max_i,
  output logic            adv_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_word_t       out_word_o
);

  logic [TPW-1:0] pos_q, pos_d, pos_n;
  logic [SCW-1:0] best_q, best_d, best_n;
  logic [TPW-1:0] end_q, end_d, end_n;
  logic           out_valid_q, out_valid_d;
  out_word_t      out_q, out_d;
  logic           blocked, emit, nm;

  // a final word cannot leave while the previous result is still held
  assign blocked = tok_i.valid && tok_i.last && out_valid_q && !out_ready_i;
  assign adv_o   = !blocked;
  assign emit    = tok_i.valid && tok_i.last && !blocked;

  always_comb begin
    pos_n  = pos_q;
    best_n = best_q;
    end_n  = end_q;
    if (tok_i.upd) begin
      pos_n = pos_q + TPW'(1);
      if (tok_i.left < best_q) begin
        best_n = tok_i.left;
        end_n  = pos_q + TPW'(1);
      end
    end
    nm = 32'(best_n) > 32'(max_i);
  end

  always_comb begin
    pos_d       = pos_q;
    best_d      = best_q;
    end_d       = end_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (load_i.restart) begin
      pos_d  = '0;
      best_d = SCW'(load_i.len) + SCW'(1);
      end_d  = '0;
    end else if (tok_i.valid && !blocked) begin
      pos_d  = pos_n;
      best_d = best_n;
      end_d  = end_n;
      if (tok_i.last) begin
        pos_d                = '0;
        best_d               = SCW'(len_i) + SCW'(1);
        end_d                = '0;
        out_valid_d          = 1'b1;
        out_d.no_match       = nm;
        out_d.distance       = nm ? 6'd0 : 6'(best_n);
        out_d.end_position   = nm ? 7'd0 : 7'(end_n);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      best_q      <= SCW'(1);
      end_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      best_q      <= best_d;
      end_q       <= end_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

>>> hdl/semi_global_edit_distance.sv
// Top level: pattern load control, systolic row of DP cells, result tail and register port.
`timescale 1ns / 1ps
// A text word passes through the registers of all MAX_PATTERN cells, then the result
//   register; the result appears only for a final text word.
// Throughput: one text word per cycle while no held result stalls the row, set by the cells advancing in lockstep.
// A pattern word is taken only once the cell row is empty.
// Reset: asynchronous, active low; clears pattern length, text state and the
//   threshold register (back to 2); pattern symbols are undefined until loaded.

module semi_global_edit_distance
  import sged_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // input words
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_word_t          in_word_i,
  // result words
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_word_t         out_word_o,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  // ---------------------------------------------------------------------------
  // Threshold register. Only the aligned address decodes; anything else is
  // dropped on write and reads as zero.
  // ---------------------------------------------------------------------------
  logic [MAXW-1:0] max_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_MAX_EDIT_ADDR);
  assign prdata = (paddr == REG_MAX_EDIT_ADDR) ? CFG_DW'(max_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MAX_EDIT_RESET;
    end else if (cfg_wr) begin
      max_q <= pwdata[MAXW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Input control: pattern length, closed flag and text counter at entry.
  // ---------------------------------------------------------------------------
  logic [PLW-1:0] len_q, len_d, eff_len;
  logic           closed_q, closed_d;
  logic [TPW-1:0] cnt_q, cnt_d;
  logic           adv, busy, acc_pat, acc_txt, upd;
  load_t          load;
  token_t         tok [MAX_PATTERN+1];

  // row must drain before a pattern word reinitialises the cells
  always_comb begin
    busy = 1'b0;
    for (int i = 1; i <= MAX_PATTERN; i++) begin
      busy = busy | tok[i].valid;
    end
  end

  assign in_ready_o = (in_word_i.opcode == OP_TEXT) ? adv : !busy;
  assign acc_pat    = in_valid_i && in_ready_o && (in_word_i.opcode == OP_PATTERN);
  assign acc_txt    = in_valid_i && in_ready_o && (in_word_i.opcode == OP_TEXT);
  assign eff_len    = closed_q ? '0 : len_q;
  assign upd        = cnt_q < TPW'(MAX_TEXT);

  always_comb begin
    len_d       = len_q;
    closed_d    = closed_q;
    cnt_d       = cnt_q;
    load        = '0;
    load.symbol = in_word_i.symbol;
    if (acc_pat) begin
      // a closed pattern restarts; overflow symbols are dropped
      len_d = eff_len;
      if (eff_len < PLW'(MAX_PATTERN)) begin
        load.wr  = 1'b1;
        load.idx = eff_len + PLW'(1);
        len_d    = eff_len + PLW'(1);
      end
      load.restart = 1'b1;
      load.len     = len_d;
      closed_d     = in_word_i.last;
      cnt_d        = '0;
    end else if (acc_txt) begin
      closed_d = 1'b1;
      if (in_word_i.last) begin
        cnt_d = '0;
      end else if (upd) begin
        cnt_d = cnt_q + TPW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      closed_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      len_q    <= len_d;
      closed_q <= closed_d;
      cnt_q    <= cnt_d;
    end
  end

  // word entering the first cell: row 0 is always zero, so left and diag are 0
  always_comb begin
    tok[0]        = '0;
    tok[0].valid  = acc_txt;
    tok[0].upd    = upd;
    tok[0].last   = in_word_i.last;
    tok[0].symbol = in_word_i.symbol;
  end

  // ---------------------------------------------------------------------------
  // Cell row. Cell j computes row j of the column from the token registered by cell j-1.
  // Cells beyond the pattern length pass the left score through, so the last
  // cell delivers the full-pattern row. A final word resets each cell behind it.
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    sged_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (PLW'(g + 1)),
      .len_i  (len_q),
      .load_i (load),
      .adv_i  (adv),
      .tok_i  (tok[g]),
      .tok_o  (tok[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Tail: running minimum, first position reaching it, result register.
  // Stalls the whole row when a final word meets a full result register.
  // ---------------------------------------------------------------------------
  sged_tail u_tail (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_i       (tok[MAX_PATTERN]),
    .load_i      (load),
    .len_i       (len_q),
    .max_i       (max_q),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

>>> hdl/sged_checker.sv
// Port-level checks for the semi-global edit distance block, bound to the top level.
`timescale 1ns / 1ps

module sged_checker
  import sged_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_word_t  in_word_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_word_o
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // no-match report carries zero fields
  a_nomatch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.no_match |->
      out_word_o.distance == 6'd0 && out_word_o.end_position == 7'd0)
    else $error("no-match word with non-zero fields");

  // a match always has a text position
  a_match_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.no_match |-> out_word_o.end_position != 7'd0)
    else $error("match reported at position zero");

  // pattern word only taken on an empty row, so no result can follow at once
  a_pat_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_word_i.opcode == OP_PATTERN && !out_valid_o
      |=> !out_valid_o)
    else $error("result raised straight after a pattern word");

endmodule

bind semi_global_edit_distance sged_checker u_sged_checker (.*);

>>> test/semi_global_edit_distance_test.sv
// Self-checking bench for the semi-global edit distance block, with a built-in predictor.
`timescale 1ns / 1ps

module semi_global_edit_distance_test;
  import sged_pkg::*;

  // cycles to let the cell row empty before a register write or the final verdict
  localparam int unsigned SETTLE_CYCLES = MAX_PATTERN + 8;
  // long receiver hold-off, enough for the row to back up into the input
  localparam int unsigned STALL_CYCLES  = 250;
  localparam int unsigned PHASE_WORDS   = 200;
  localparam int unsigned NUM_PHASES    = 10;
  localparam int unsigned STALL_PHASE   = 5;
  localparam int unsigned NO_IDLE_PHASE = 3;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;

  logic            in_valid = 1'b0;
  logic            in_ready;
  in_word_t        in_word = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  out_word_t       out_word;

  logic            psel = 1'b0;
  logic            penable = 1'b0;
  logic            pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic            pready;

  semi_global_edit_distance u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor: alignment state mirrored at the block's own widths
  // ---------------------------------------------------------------------------
  logic [7:0]      pat_sym [MAX_PATTERN];
  logic [PLW-1:0]  pat_len = '0;
  logic            pat_closed = 1'b0;
  logic [SCW-1:0]  col_score [MAX_PATTERN+1];
  logic [TPW-1:0]  txt_pos;
  logic [SCW-1:0]  best_score;
  logic [TPW-1:0]  best_end;
  logic [MAXW-1:0] max_edit = MAX_EDIT_RESET;

  out_word_t       expected_q [$];   // results still owed by the block, oldest first
  in_word_t        pending_q [$];    // words waiting to be offered
  out_word_t       want;
  int unsigned     error_count = 0;

  // stimulus control, written by the sequencing process only
  int unsigned     idle_pct = 17;
  logic            stall_phase = 1'b0;
  logic            short_texts = 1'b0;
  int unsigned     phase_words = 0;
  logic [7:0]      gen_pat [$];      // pattern as generated, used to plant near-matches

  // fresh DP column: row j scores j, no best yet
  function automatic void restart_text();
    int j;
    for (j = 0; j <= MAX_PATTERN; j++) col_score[j] = SCW'(j);
    txt_pos    = '0;
    best_score = SCW'(pat_len) + SCW'(1);
    best_end   = '0;
  endfunction

  function automatic void predict_word(in_word_t w);
    out_word_t      r;
    logic [SCW-1:0] diag, up_old, m;
    int             j;
    if (w.opcode == OP_PATTERN) begin
      // a pattern word after a closed pattern starts a new one
      if (pat_closed) begin
        pat_len    = '0;
        pat_closed = 1'b0;
      end
      // symbols past the store are dropped, last still closes
      if (pat_len < MAX_PATTERN) begin
        pat_sym[pat_len] = w.symbol;
        pat_len++;
      end
      if (w.last) pat_closed = 1'b1;
      // also abandons any text in progress
      restart_text();
    end else begin
      pat_closed = 1'b1;
      // text beyond MAX_TEXT leaves the column alone
      if (txt_pos < MAX_TEXT) begin
        diag         = col_score[0];
        col_score[0] = '0;  // free start anywhere in the text
        for (j = 1; j <= int'(pat_len); j++) begin
          up_old = col_score[j];
          if (pat_sym[j-1] == w.symbol) begin
            col_score[j] = diag;
          end else begin
            m = (up_old < col_score[j-1]) ? up_old : col_score[j-1];
            if (diag < m) m = diag;
            col_score[j] = m + SCW'(1);
          end
          diag = up_old;
        end
        txt_pos++;
        // strict less-than keeps the first position reaching the minimum
        if (col_score[pat_len] < best_score) begin
          best_score = col_score[pat_len];
          best_end   = txt_pos;
        end
      end
      if (w.last) begin
        if (best_score > SCW'(max_edit)) begin
          r.distance     = '0;
          r.no_match     = 1'b1;
          r.end_position = '0;
        end else begin
          r.distance     = best_score;
          r.no_match     = 1'b0;
          r.end_position = best_end;
        end
        expected_q = {expected_q, r};
        restart_text();
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: everything sampled at the rising edge
  // ---------------------------------------------------------------------------
  logic in_taken = 1'b0;

  always @(posedge clk_i) begin
    in_taken <= in_valid && in_ready;
    if (in_valid && in_ready) predict_word(in_word);
    if (out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected: %p", out_word);
        error_count++;
      end else begin
        want = expected_q.pop_front();
        if (out_word.distance !== want.distance) begin
          $error("distance: expected %0d, got %0d", want.distance, out_word.distance);
          error_count++;
        end
        if (out_word.no_match !== want.no_match) begin
          $error("no_match: expected %0d, got %0d", want.no_match, out_word.no_match);
          error_count++;
        end
        if (out_word.end_position !== want.end_position) begin
          $error("end_position: expected %0d, got %0d", want.end_position,
                 out_word.end_position);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: next word offered at the falling edge once the current one is gone
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_taken)) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_word  <= pending_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off in the stall phase
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni && stall_phase && !hold_done) begin
      hold_left = STALL_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_ni && ($urandom_range(99) >= idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Register port and sequencing helpers
  // ---------------------------------------------------------------------------

  // write the threshold, then read it back; only called with the block idle
  task automatic write_threshold(logic [MAXW-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_MAX_EDIT_ADDR;
    pwdata  <= CFG_DW'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    max_edit = value;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[MAXW-1:0] !== value) begin
      $error("max_edit_distance: expected %0d, got %0d", value, prdata[MAXW-1:0]);
      error_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // sender pause: every word taken, every result back, row drained
  task automatic drain();
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic void push_word(logic op, logic [7:0] sym, logic fin);
    in_word_t w;
    w.opcode = op;
    w.symbol = sym;
    w.last   = fin;
    pending_q = {pending_q, w};
    phase_words++;
  endfunction

  // mostly a four-letter alphabet so that matches happen; any byte otherwise
  function automatic logic [7:0] pick_symbol();
    if ($urandom_range(9) < 3) return 8'($urandom_range(255));
    case ($urandom_range(3))
      0:       return 8'h41;
      1:       return 8'h43;
      2:       return 8'h47;
      default: return 8'h54;
    endcase
  endfunction

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (short_texts) return $urandom_range(1, 3);
    if (r < 60) return $urandom_range(1, 8);
    if (r < 85) return $urandom_range(9, 20);
    if (r < 95) return $urandom_range(21, MAX_PATTERN);
    return $urandom_range(MAX_PATTERN + 1, MAX_PATTERN + 8);  // overlong, tail dropped
  endfunction

  function automatic void load_pattern(int unsigned len, logic close);
    logic [7:0]  s;
    int unsigned i;
    gen_pat.delete();
    for (i = 0; i < len; i++) begin
      s = pick_symbol();
      if (i < MAX_PATTERN) gen_pat = {gen_pat, s};
      push_word(OP_PATTERN, s, close && (i == len - 1));
    end
  endfunction

  // random flanks, usually around a lightly mutated copy of the pattern
  function automatic void send_text(logic finish);
    logic [7:0]  txt [$];
    int unsigned i, r, target;
    repeat ($urandom_range(6)) txt = {txt, pick_symbol()};
    if ($urandom_range(9) < 7) begin
      foreach (gen_pat[k]) begin
        r = $urandom_range(99);
        if (r < 6) begin
          txt = {txt, pick_symbol()};
        end else if (r < 14) begin
          if (r < 10) continue;  // deletion
          txt = {txt, pick_symbol()};
          txt = {txt, gen_pat[k]};
        end else begin
          txt = {txt, gen_pat[k]};
        end
      end
    end
    repeat ($urandom_range(6)) txt = {txt, pick_symbol()};
    // now and then run past the text limit
    if ($urandom_range(14) == 0) begin
      target = $urandom_range(MAX_TEXT - 4, MAX_TEXT + 8);
      while (txt.size() < target) txt = {txt, pick_symbol()};
    end
    if (short_texts) while (txt.size() > 3) void'(txt.pop_front());
    if (txt.size() == 0) txt = {txt, pick_symbol()};
    for (i = 0; i < txt.size(); i++)
      push_word(OP_TEXT, txt[i], finish && (i == txt.size() - 1));
  endfunction

  // ---------------------------------------------------------------------------
  // Sequencing: directed words first, then random phases between threshold writes
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned phase, r;
    restart_text();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // text straight after reset runs against the empty pattern, reset threshold
    push_word(OP_TEXT, 8'h41, 1'b1);
    push_word(OP_TEXT, 8'h00, 1'b0);
    push_word(OP_TEXT, 8'hFF, 1'b1);
    // exact hit inside the text
    push_word(OP_PATTERN, 8'h41, 1'b0);
    push_word(OP_PATTERN, 8'h43, 1'b1);
    push_word(OP_TEXT, 8'h47, 1'b0);
    push_word(OP_TEXT, 8'h41, 1'b0);
    push_word(OP_TEXT, 8'h43, 1'b0);
    push_word(OP_TEXT, 8'h54, 1'b1);
    drain();

    // zero threshold: one substitution is already no match
    write_threshold(MAXW'(0));
    push_word(OP_TEXT, 8'h41, 1'b0);
    push_word(OP_TEXT, 8'h47, 1'b1);
    // extreme bytes, pattern left open and closed by the text
    push_word(OP_PATTERN, 8'h00, 1'b0);
    push_word(OP_PATTERN, 8'hFF, 1'b0);
    push_word(OP_TEXT, 8'hFF, 1'b0);
    push_word(OP_TEXT, 8'h00, 1'b0);
    push_word(OP_TEXT, 8'hFF, 1'b1);
    // pattern word mid-text abandons the text and starts a new pattern
    push_word(OP_TEXT, 8'h41, 1'b0);
    push_word(OP_PATTERN, 8'h41, 1'b1);
    push_word(OP_PATTERN, 8'h54, 1'b1);
    push_word(OP_TEXT, 8'h43, 1'b0);
    push_word(OP_TEXT, 8'h54, 1'b1);
    drain();

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0, STALL_PHASE: write_threshold(MAXW'(32));
        1:              write_threshold(MAXW'(0));
        4:              write_threshold(MAXW'(1));
        7:              write_threshold(MAXW'(3));
        9:              write_threshold(MAX_EDIT_RESET);
        default:        write_threshold(MAXW'($urandom_range(32)));
      endcase
      idle_pct    = (phase == NO_IDLE_PHASE) ? 0 : 17;
      short_texts = (phase == STALL_PHASE);
      stall_phase = (phase == STALL_PHASE);
      phase_words = 0;
      while (phase_words < PHASE_WORDS) begin
        r = $urandom_range(99);
        if (r < 70) begin
          // well-formed: closed pattern, a few texts against it
          load_pattern(pick_len(), 1'b1);
          repeat ($urandom_range(1, 4)) send_text(1'b1);
        end else if (r < 80) begin
          // text closes a pattern that was never marked last
          load_pattern(pick_len(), 1'b0);
          send_text(1'b1);
        end else if (r < 88) begin
          send_text(1'b1);
        end else if (r < 94) begin
          // unfinished text, cut off by the next pattern
          send_text(1'b0);
          load_pattern(pick_len(), 1'b1);
          send_text(1'b1);
        end else begin
          // noise: any opcode, any marker
          repeat ($urandom_range(1, 5))
            push_word(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)));
        end
      end
      drain();
      stall_phase = 1'b0;
    end

    if (error_count == 0) begin
      $display("semi_global_edit_distance_test: done, clean");
    end else begin
      $display("semi_global_edit_distance_test: done, errors");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("semi_global_edit_distance_test: done, errors");
    $finish;
  end

endmodule
